// File: hw/rtl/ktbl_pkg.sv
`default_nettype none
package ktbl_pkg;
    localparam logic [1:0] CMD_ALLOW  = 2'd0;
    localparam logic [1:0] CMD_STATUS = 2'd1;
    localparam logic [1:0] CMD_CONFIG = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [0:0] REG_DEFAULT_RATE = 1'b0;
    localparam logic [0:0] REG_DEFAULT_CAP  = 1'b1;

    localparam int MT_PER_TOKEN = 1000;
    localparam int LEVEL_W      = 26;
    localparam int ENTRY_W      = 16 + 16 + LEVEL_W + 32;

    // bucket entry as stored in the table
    typedef struct packed {
        logic [15:0]        rate;
        logic [15:0]        capacity;
        logic [LEVEL_W-1:0] tokens;
        logic [31:0]        last_time;
    } t_entry;

    // divider control
    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] dividend;
        logic [15:0]        divisor;
    } t_div_req;
endpackage
`default_nettype wire

// File: hw/rtl/ktbl_ram.sv
`default_nettype none
module ktbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/ktbl_div.sv
`default_nettype none
module ktbl_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ktbl_pkg::t_div_req i_req,
    output logic                    o_done,
    output logic [ktbl_pkg::LEVEL_W-1:0] o_quot
);
    import ktbl_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_W + 1);

    logic [LEVEL_W-1:0] r_quot;
    logic [16:0]        r_rem;
    logic [15:0]        r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [16:0]        w_shift;
    logic [17:0]        w_diff;

    assign w_shift = {r_rem[15:0], r_quot[LEVEL_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(LEVEL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[17]) begin
                r_rem  <= w_diff[16:0];
                r_quot <= {r_quot[LEVEL_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[LEVEL_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: hw/rtl/keyed_token_bucket_limiter_core.sv
`default_nettype none
// Keyed token-bucket limiter: a table of FLOWS buckets held in one RAM.
// Input channel s_axis: tdata = command, flow_index, now_ms, cost,
// new_rate, new_capacity. Output channel m_axis: one result per request.
// Configuration port: i_cfg_we/i_cfg_index/i_cfg_wdata set default_rate (0)
// and default_capacity (1); write only while idle.
// Each request is processed one at a time: the table read is issued at the
// accepting edge, then entry capture, refill multiply, saturate, decision
// and write-back, and output load follow, each in its own state. A denied
// allow also runs the radix-2 divider, 26 quotient steps, and the quotient
// is taken into the result before the output load. The next request is
// taken the cycle after the result is loaded.
// While the receiver stalls, the result is held in the output register; one
// more request may be taken and processed, and it waits until the output
// register frees. No further request enters meanwhile.
// Reset clears the valid bits (flip-flops, one per entry) and restores the
// default registers to 20 and 50; no clearing pass is needed. Entries never
// used are created from the defaults on first access.
module keyed_token_bucket_limiter_core #(
    parameter int FLOWS = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // command[1:0], flow_index[9:2], now_ms[41:10], cost[57:42],
    // new_rate[73:58], new_capacity[89:74], zero fill to 96
    input  wire logic [95:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // allowed[0], config_ok[1], retry_ms[27:2], remaining_mt[53:28],
    // rate_out[69:54], capacity_out[85:70], since_refill_ms[117:86], zero fill
    output logic [119:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_wdata
);
    import ktbl_pkg::*;

    localparam int AW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SAT  = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]         r_state;
    logic [15:0]        r_def_rate;
    logic [15:0]        r_def_cap;
    logic [FLOWS-1:0]   r_valid;

    logic [1:0]         r_cmd;
    logic [7:0]         r_idx;
    logic [31:0]        r_now;
    logic [15:0]        r_cost;
    logic [15:0]        r_nrate;
    logic [15:0]        r_ncap;
    logic               r_hit;
    t_entry             r_ent;
    logic [47:0]        r_prod;
    logic [31:0]        r_lim;
    logic [LEVEL_W-1:0] r_need;
    logic [119:0]       r_res;
    logic [119:0]       r_out;
    logic               r_out_valid;

    t_entry             w_rdata;
    t_entry             w_base;
    t_entry             w_wdata;
    logic               w_we;
    logic [31:0]        w_elapsed;
    logic [48:0]        w_level;
    logic [LEVEL_W-1:0] w_tok;
    logic               w_in_range;
    logic               w_fire;
    logic               w_out_free;
    logic [119:0]       w_res;
    t_div_req           w_div_req;
    logic               w_div_done;
    logic [LEVEL_W-1:0] w_quot;

    assign w_fire     = s_axis_tvalid && s_axis_tready;
    assign w_in_range = ({24'd0, s_axis_tdata[9:2]} < 32'(FLOWS));
    assign w_out_free = !r_out_valid || m_axis_tready;

    ktbl_ram #(.WIDTH(ENTRY_W), .DEPTH(FLOWS)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_idx[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(s_axis_tdata[AW+1:2]),
        .o_rdata(w_rdata)
    );

    // default registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_rate <= 16'd20;
            r_def_cap  <= 16'd50;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_DEFAULT_RATE) r_def_rate <= i_cfg_wdata;
            if (i_cfg_index == REG_DEFAULT_CAP)  r_def_cap  <= i_cfg_wdata;
        end
    end

    // entry as seen after optional creation from the defaults
    always_comb begin
        w_base = w_rdata;
        if (!r_valid[r_idx[AW-1:0]]) begin
            w_base.rate      = (r_def_rate == 16'd0) ? 16'd1 : r_def_rate;
            w_base.capacity  = (r_def_cap == 16'd0) ? 16'd1 : r_def_cap;
            w_base.tokens    = LEVEL_W'(32'(w_base.capacity) * MT_PER_TOKEN);
            w_base.last_time = r_now;
        end
    end

    assign w_elapsed = r_now - r_ent.last_time;
    assign w_level   = 49'(r_ent.tokens) + 49'(r_prod);
    assign w_tok     = r_ent.tokens;

    // write-back of the refilled or configured entry
    always_comb begin
        w_wdata = r_ent;
        w_we    = (r_state == ST_DEC) && r_hit;
        if (r_cmd == CMD_CONFIG) begin
            w_wdata.rate      = r_nrate;
            w_wdata.capacity  = r_ncap;
            w_wdata.tokens    = LEVEL_W'(32'(r_ncap) * MT_PER_TOKEN);
            w_wdata.last_time = r_now;
        end else if (r_cmd == CMD_ALLOW && w_tok >= r_need) begin
            w_wdata.tokens = w_tok - r_need;
        end
    end

    // result fields; all zero for a rejected or unknown request
    always_comb begin
        w_res = '0;
        if (r_hit) begin
            w_res[0]      = (r_cmd == CMD_ALLOW) && (w_tok >= r_need);
            w_res[1]      = 1'b1;
            w_res[53:28]  = w_wdata.tokens;
            w_res[69:54]  = w_wdata.rate;
            w_res[85:70]  = w_wdata.capacity;
            w_res[117:86] = r_now - w_wdata.last_time;
        end
    end

    assign w_div_req.start    = (r_state == ST_DEC) && r_hit && (r_cmd == CMD_ALLOW)
                                && (w_tok < r_need);
    assign w_div_req.dividend = r_need - w_tok;
    assign w_div_req.divisor  = r_ent.rate;

    ktbl_div u_div (
        .i_clk (i_clk),
        .i_rst_n(i_rst_n),
        .i_req (w_div_req),
        .o_done(w_div_done),
        .o_quot(w_quot)
    );

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load the output register, or release it on a transaction
            if (r_state == ST_OUT && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (w_fire) r_state <= ST_READ;
                ST_READ: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_SAT;
                ST_SAT:  r_state <= ST_DEC;
                ST_DEC: begin
                    if (w_we) r_valid[r_idx[AW-1:0]] <= 1'b1;
                    r_state <= w_div_req.start ? ST_DIV : ST_OUT;
                end
                ST_DIV:  if (w_div_done) r_state <= ST_OUT;
                ST_OUT:  if (w_out_free) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (w_fire) begin
                r_cmd   <= s_axis_tdata[1:0];
                r_idx   <= s_axis_tdata[9:2];
                r_now   <= s_axis_tdata[41:10];
                r_cost  <= s_axis_tdata[57:42];
                r_nrate <= s_axis_tdata[73:58];
                r_ncap  <= s_axis_tdata[89:74];
                r_hit   <= w_in_range && (s_axis_tdata[1:0] != CMD_NONE) &&
                           !(s_axis_tdata[1:0] == CMD_CONFIG &&
                             (s_axis_tdata[73:58] == 16'd0 ||
                              s_axis_tdata[89:74] == 16'd0));
            end
            ST_READ: begin
                r_ent  <= w_base;
                r_need <= LEVEL_W'(32'((r_cost == 16'd0) ? 16'd1 : r_cost) *
                          MT_PER_TOKEN);
            end
            ST_MUL: begin
                r_prod <= 48'(w_elapsed) * 48'(r_ent.rate);
                r_lim  <= 32'(r_ent.capacity) * MT_PER_TOKEN;
            end
            ST_SAT: begin
                if (w_elapsed != 32'd0 && r_cmd != CMD_CONFIG) begin
                    r_ent.tokens    <= (w_level > 49'(r_lim)) ? LEVEL_W'(r_lim)
                                                              : LEVEL_W'(w_level);
                    r_ent.last_time <= r_now;
                end
            end
            ST_DEC:  r_res <= w_res;
            ST_DIV:  if (w_div_done) r_res[27:2] <= w_quot;
            ST_OUT:  if (w_out_free) r_out <= r_res;
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result lost under stall");
    a_div_only_deny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> (r_cmd == CMD_ALLOW)) else $error("divider misuse");
    a_deny_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[27:2] == 26'd0))
        else $error("retry on grant");
`endif
endmodule
`default_nettype wire
